// ===== src/snfcs_pkg.sv =====
// Package for the SPI NOR flash command sequencer: item types, codes, constants.
// No dependencies.
`default_nettype none
package snfcs_pkg;

  localparam int unsigned PageBytesDefault   = 256;
  localparam int unsigned SectorBytesDefault = 4096;
  localparam int unsigned QueueDepth         = 2;

  localparam logic [15:0] TimeoutReset = 16'd10000;

  typedef enum logic [2:0] {
    ACT_READ  = 3'd0,
    ACT_PROG  = 3'd1,
    ACT_ERASE = 3'd2,
    ACT_BYTE  = 3'd3,
    ACT_DATA  = 3'd4,
    ACT_TICK  = 3'd5,
    ACT_RSV6  = 3'd6,
    ACT_RSV7  = 3'd7
  } action_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RD_HDR    = 4'd1,
    PH_RD_DATA   = 4'd2,
    PH_WREN      = 4'd3,
    PH_CMD_HDR   = 4'd4,
    PH_WAIT_DATA = 4'd5,
    PH_PROG_DATA = 4'd6,
    PH_POLL_CMD  = 4'd7,
    PH_POLL_STAT = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_PROG  = 2'd1,
    KIND_ERASE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_XFER_ERR = 2'd1,
    ST_TIMEOUT  = 2'd2,
    ST_REJECTED = 2'd3
  } status_t;

  localparam logic [7:0] OP_READ   = 8'h03;
  localparam logic [7:0] OP_PROG   = 8'h02;
  localparam logic [7:0] OP_WREN   = 8'h06;
  localparam logic [7:0] OP_ERASE  = 8'h20;
  localparam logic [7:0] OP_STATUS = 8'h05;
  localparam logic [7:0] DUMMY     = 8'hFF;

  typedef struct packed {
    logic [2:0]  action;
    logic [23:0] address;
    logic [23:0] length;
    logic [7:0]  rx_byte;
    logic        xfer_error;
    logic [7:0]  write_byte;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       frame_start;
    logic       frame_end;
    logic       read_valid;
    logic [7:0] read_data;
    logic       need_data;
    logic       done_res;
    logic [1:0] status;
    logic       busy_res;
  } out_item_t;

  // Classified event handed from front to back
  typedef struct packed {
    logic       is_cmd;
    logic       is_byte;
    logic       is_data;
    logic       is_tick;
    kind_t      kind;
    in_item_t   item;
  } event_t;

endpackage
`default_nettype wire

// ===== src/snfcs_front.sv =====
// Front end: accepts input items, classifies them and queues them for the engine.
// Depends on snfcs_pkg.
`default_nettype none
module snfcs_front
  import snfcs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_item,
  output logic          ev_valid,
  output event_t        ev,
  input  wire logic     ev_take
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  event_t         mem [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;
  event_t         cls;
  logic           do_push;
  logic           do_pop;

  // Classify the incoming action
  always_comb begin
    cls         = '0;
    cls.item    = in_item;
    cls.kind    = kind_t'(in_item.action[1:0]);
    unique case (action_t'(in_item.action))
      ACT_READ, ACT_PROG, ACT_ERASE: cls.is_cmd = 1'b1;
      ACT_BYTE:                      cls.is_byte = 1'b1;
      ACT_DATA:                      cls.is_data = 1'b1;
      ACT_TICK:                      cls.is_tick = 1'b1;
      default:                       cls.is_cmd = 1'b0;
    endcase
  end

  assign full     = (count == (PtrW+1)'(QueueDepth));
  assign do_push  = push && !full;
  assign ev_valid = (count != '0);
  assign do_pop   = ev_valid && ev_take;
  assign ev       = mem[rd_ptr];

  // Store classified items
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= cls;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PtrW'(QueueDepth-1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PtrW'(QueueDepth-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ===== src/snfcs_engine.sv =====
// Back end: flash FSM, one event per cycle into a result register unless a result waits.
// Depends on snfcs_pkg.
`default_nettype none
module snfcs_engine
  import snfcs_pkg::*;
#(
  parameter int unsigned PAGE_BYTES   = PageBytesDefault,
  parameter int unsigned SECTOR_BYTES = SectorBytesDefault
)(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [15:0] busy_timeout_ms,
  input  wire logic        ev_valid,
  input  wire event_t      ev,
  output logic             ev_take,
  output logic             res_valid,
  output out_item_t        res,
  input  wire logic        res_take
);

  localparam int unsigned PageW = $clog2(PAGE_BYTES);

  phase_t      phase, phase_next;
  kind_t       kind, kind_next;
  logic [23:0] cur_addr, cur_addr_next;
  logic [23:0] bytes_left, bytes_left_next;
  logic [8:0]  chunk_left, chunk_left_next;
  logic [1:0]  hdr_idx, hdr_idx_next;
  logic [15:0] wait_ticks, wait_ticks_next;
  out_item_t   o;
  logic [23:0] room;
  logic [23:0] bl_dec;

  assign ev_take = ev_valid && (!res_valid || res_take);
  assign bl_dec  = bytes_left - 24'd1;

  // Process one event
  always_comb begin
    phase_next      = phase;
    kind_next       = kind;
    cur_addr_next   = cur_addr;
    bytes_left_next = bytes_left;
    chunk_left_next = chunk_left;
    hdr_idx_next    = hdr_idx;
    wait_ticks_next = wait_ticks;
    o               = '0;
    room            = 24'(PAGE_BYTES) - 24'(cur_addr[PageW-1:0]);

    if (ev.is_cmd) begin
      if (phase != PH_IDLE) begin
        o.status = ST_REJECTED;
      end else begin
        kind_next       = ev.kind;
        cur_addr_next   = ev.item.address;
        bytes_left_next = ev.item.length;
        hdr_idx_next    = '0;
        if (ev.kind == KIND_READ) begin
          phase_next    = PH_RD_HDR;
          o.tx_valid    = 1'b1;
          o.tx_byte     = OP_READ;
          o.frame_start = 1'b1;
        end else if (ev.item.length == '0) begin
          o.done_res = 1'b1;
          phase_next = PH_IDLE;
        end else begin
          room = 24'(PAGE_BYTES) - 24'(ev.item.address[PageW-1:0]);
          if (ev.kind == KIND_PROG)
            chunk_left_next = (ev.item.length < room) ? ev.item.length[8:0] : room[8:0];
          phase_next    = PH_WREN;
          o.tx_valid    = 1'b1;
          o.tx_byte     = OP_WREN;
          o.frame_start = 1'b1;
          o.frame_end   = 1'b1;
        end
      end
    end else if (ev.is_byte && phase != PH_IDLE && phase != PH_WAIT_DATA) begin
      if (ev.item.xfer_error) begin
        o.done_res  = 1'b1;
        o.status    = ST_XFER_ERR;
        o.frame_end = 1'b1;
        phase_next  = PH_IDLE;
      end else begin
        unique case (phase)
          PH_RD_HDR, PH_CMD_HDR: begin
            if (hdr_idx != 2'd3) begin
              hdr_idx_next = hdr_idx + 2'd1;
              o.tx_valid   = 1'b1;
              unique case (hdr_idx)
                2'd0:    o.tx_byte = cur_addr[23:16];
                2'd1:    o.tx_byte = cur_addr[15:8];
                default: o.tx_byte = cur_addr[7:0];
              endcase
              o.frame_end = (hdr_idx == 2'd2) &&
                            (kind == KIND_ERASE || (kind == KIND_READ && bytes_left == '0));
            end else if (kind == KIND_READ) begin
              if (bytes_left == '0) begin
                o.done_res = 1'b1;
                phase_next = PH_IDLE;
              end else begin
                phase_next  = PH_RD_DATA;
                o.tx_valid  = 1'b1;
                o.tx_byte   = DUMMY;
                o.frame_end = (bytes_left == 24'd1);
              end
            end else if (kind == KIND_PROG) begin
              phase_next = PH_WAIT_DATA;
            end else begin
              wait_ticks_next = '0;
              phase_next      = PH_POLL_CMD;
              o.tx_valid      = 1'b1;
              o.tx_byte       = OP_STATUS;
              o.frame_start   = 1'b1;
            end
          end
          PH_RD_DATA: begin
            o.read_valid    = 1'b1;
            o.read_data     = ev.item.rx_byte;
            bytes_left_next = bl_dec;
            if (bl_dec == '0) begin
              o.done_res = 1'b1;
              phase_next = PH_IDLE;
            end else begin
              o.tx_valid  = 1'b1;
              o.tx_byte   = DUMMY;
              o.frame_end = (bl_dec == 24'd1);
            end
          end
          PH_WREN: begin
            phase_next    = PH_CMD_HDR;
            hdr_idx_next  = '0;
            o.tx_valid    = 1'b1;
            o.tx_byte     = (kind == KIND_PROG) ? OP_PROG : OP_ERASE;
            o.frame_start = 1'b1;
          end
          PH_PROG_DATA: begin
            chunk_left_next = chunk_left - 9'd1;
            bytes_left_next = bl_dec;
            cur_addr_next   = cur_addr + 24'd1;
            if (chunk_left != 9'd1) begin
              phase_next = PH_WAIT_DATA;
            end else begin
              wait_ticks_next = '0;
              phase_next      = PH_POLL_CMD;
              o.tx_valid      = 1'b1;
              o.tx_byte       = OP_STATUS;
              o.frame_start   = 1'b1;
            end
          end
          PH_POLL_CMD: begin
            phase_next  = PH_POLL_STAT;
            o.tx_valid  = 1'b1;
            o.tx_byte   = DUMMY;
            o.frame_end = 1'b1;
          end
          PH_POLL_STAT: begin
            if (ev.item.rx_byte[0]) begin
              if (wait_ticks >= busy_timeout_ms) begin
                o.done_res = 1'b1;
                o.status   = ST_TIMEOUT;
                phase_next = PH_IDLE;
              end else begin
                phase_next    = PH_POLL_CMD;
                o.tx_valid    = 1'b1;
                o.tx_byte     = OP_STATUS;
                o.frame_start = 1'b1;
              end
            end else begin
              if (kind == KIND_ERASE) begin
                cur_addr_next   = cur_addr + 24'(SECTOR_BYTES);
                bytes_left_next = (bytes_left > 24'(SECTOR_BYTES)) ?
                                  bytes_left - 24'(SECTOR_BYTES) : '0;
              end
              if (bytes_left_next == '0) begin
                o.done_res = 1'b1;
                phase_next = PH_IDLE;
              end else begin
                room = 24'(PAGE_BYTES) - 24'(cur_addr_next[PageW-1:0]);
                if (kind == KIND_PROG)
                  chunk_left_next = (bytes_left_next < room) ?
                                    bytes_left_next[8:0] : room[8:0];
                phase_next    = PH_WREN;
                o.tx_valid    = 1'b1;
                o.tx_byte     = OP_WREN;
                o.frame_start = 1'b1;
                o.frame_end   = 1'b1;
              end
            end
          end
          default: phase_next = phase;
        endcase
      end
    end else if (ev.is_data && phase == PH_WAIT_DATA) begin
      phase_next  = PH_PROG_DATA;
      o.tx_valid  = 1'b1;
      o.tx_byte   = ev.item.write_byte;
      o.frame_end = (chunk_left == 9'd1);
    end else if (ev.is_tick && (phase == PH_POLL_CMD || phase == PH_POLL_STAT)
                 && wait_ticks != 16'hFFFF) begin
      wait_ticks_next = wait_ticks + 16'd1;
    end

    o.need_data = (phase_next == PH_WAIT_DATA);
    o.busy_res  = (phase_next != PH_IDLE);
  end

  // Hold state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      kind       <= KIND_READ;
      cur_addr   <= '0;
      bytes_left <= '0;
      chunk_left <= '0;
      hdr_idx    <= '0;
      wait_ticks <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (ev_take) begin
        phase      <= phase_next;
        kind       <= kind_next;
        cur_addr   <= cur_addr_next;
        bytes_left <= bytes_left_next;
        chunk_left <= chunk_left_next;
        hdr_idx    <= hdr_idx_next;
        wait_ticks <= wait_ticks_next;
        res_valid  <= 1'b1;
      end else if (res_take) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_take) res <= o;
  end

endmodule
`default_nettype wire

// ===== src/spi_nor_flash_command_sequencer_core.sv =====
// SPI NOR flash command sequencer: usage and throughput
// Input is a queue: write an item with push while full is low. Each item is a host
// command (read, program, erase region), an SPI byte-done event, a program data
// byte or a 1 ms tick. Every accepted item yields exactly one result item.
// Results are a queue: while empty is low the oldest result sits on result;
// pop takes it. A result tells the SPI master what byte to send and when to
// toggle chip select, carries read data, and reports done, status and busy.
// The input queue holds each accepted item; the engine takes it from the queue head
// and loads its result into the result register.
// Throughput: one item per cycle sustained while results are popped; the engine
// updates its state once per item; the two-entry input queue plus result register
// let both sides stall independently. A stalled popper fills the result register,
// then the queue, then raises full; nothing is lost.
// busy_timeout_ms is written with cfg_we/cfg_data; the user must write it only while
// idle, which the block does not enforce; it resets to 10000.
// Synchronous reset clears the queue, the result register and goes to idle.
// Depends on snfcs_pkg, snfcs_front, snfcs_engine.
`default_nettype none
module spi_nor_flash_command_sequencer_core
  import snfcs_pkg::*;
#(
  parameter int unsigned PAGE_BYTES   = PageBytesDefault,
  parameter int unsigned SECTOR_BYTES = SectorBytesDefault
)(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire in_item_t    item,
  output logic             empty,
  input  wire logic        pop,
  output out_item_t        result,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] timeout_reg;
  logic        ev_valid;
  event_t      ev;
  logic        ev_take;
  logic        res_valid;

  // Hold the timeout register
  always_ff @(posedge clk) begin
    if (rst) timeout_reg <= TimeoutReset;
    else if (cfg_we) timeout_reg <= cfg_data;
  end

  snfcs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (item),
    .ev_valid (ev_valid),
    .ev       (ev),
    .ev_take  (ev_take)
  );

  snfcs_engine #(
    .PAGE_BYTES   (PAGE_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_engine (
    .clk             (clk),
    .rst             (rst),
    .busy_timeout_ms (timeout_reg),
    .ev_valid        (ev_valid),
    .ev              (ev),
    .ev_take         (ev_take),
    .res_valid       (res_valid),
    .res             (result),
    .res_take        (pop)
  );

  assign empty = !res_valid;

`ifndef NO_ASSERTIONS
  // A result is taken only when one is present, so a queued event must move on
  a_take_moves: assert property (@(posedge clk) disable iff (rst)
    (ev_valid && !empty && pop) |-> ev_take)
    else $error("engine stalled while result drained");

  // A held result stays put while not popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("result changed while stalled");

  // Need-data and busy agree
  a_need_busy: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.need_data) |-> result.busy_res)
    else $error("need_data without busy");
`endif

endmodule
`default_nettype wire

// ===== dv/spi_nor_flash_command_sequencer_core_test.sv =====
// Testbench for spi_nor_flash_command_sequencer_core: drives host commands, SPI byte
// events, data bytes and ticks, predicts every result and checks it in order.
// Depends on snfcs_pkg and the sequencer core RTL.
`timescale 1ns / 100ps
module spi_nor_flash_command_sequencer_core_test;
  import snfcs_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  in_item_t    item = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   result;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;

  spi_nor_flash_command_sequencer_core u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Sequencer state mirror
  logic [15:0] tmo_limit;
  phase_t      seq_phase;
  kind_t       seq_kind;
  logic [23:0] seq_addr;
  logic [23:0] seq_left;
  logic [8:0]  seq_chunk;
  logic [1:0]  seq_hdr;
  logic [15:0] seq_ticks;
  out_item_t   frame_q[$];
  int          mismatches = 0;
  int          send_idle = 0;
  int          pop_idle = 0;
  int          sent_items = 0;

  function automatic void put_byte(inout out_item_t r, input logic [7:0] b,
                                   input logic s, input logic e);
    r.tx_valid = 1'b1; r.tx_byte = b; r.frame_start = s; r.frame_end = e;
  endfunction

  function automatic void end_cmd(inout out_item_t r, input status_t st);
    r.done_res = 1'b1; r.status = st;
    if (st == ST_XFER_ERR) r.frame_end = 1'b1;
    seq_phase = PH_IDLE;
  endfunction

  function automatic void begin_step(inout out_item_t r);
    logic [8:0] room;
    room = 9'd256 - {1'b0, seq_addr[7:0]};
    if (seq_kind == KIND_PROG) seq_chunk = (seq_left < room) ? seq_left[8:0] : room;
    seq_phase = PH_WREN;
    put_byte(r, OP_WREN, 1'b1, 1'b1);
  endfunction

  function automatic void begin_poll(inout out_item_t r, input logic fresh);
    if (fresh) seq_ticks = '0;
    seq_phase = PH_POLL_CMD;
    put_byte(r, OP_STATUS, 1'b1, 1'b0);
  endfunction

  function automatic void send_addr(inout out_item_t r);
    logic last;
    last = (seq_hdr == 2'd3) && (seq_kind == KIND_ERASE ||
           (seq_kind == KIND_READ && seq_left == 0));
    put_byte(r, 8'(seq_addr >> (8 * (3 - seq_hdr))), 1'b0, last);
  endfunction

  // Advance the mirror for one finished SPI byte
  function automatic void spi_byte_done(inout out_item_t r, input logic [7:0] rx);
    case (seq_phase)
      PH_RD_HDR, PH_CMD_HDR: begin
        if (seq_hdr < 2'd3) begin
          seq_hdr++;
          send_addr(r);
        end else if (seq_kind == KIND_READ) begin
          if (seq_left == 0) end_cmd(r, ST_OK);
          else begin
            seq_phase = PH_RD_DATA;
            put_byte(r, DUMMY, 1'b0, seq_left == 1);
          end
        end else if (seq_kind == KIND_PROG) seq_phase = PH_WAIT_DATA;
        else begin_poll(r, 1'b1);
      end
      PH_RD_DATA: begin
        r.read_valid = 1'b1; r.read_data = rx;
        seq_left--;
        if (seq_left == 0) end_cmd(r, ST_OK);
        else put_byte(r, DUMMY, 1'b0, seq_left == 1);
      end
      PH_WREN: begin
        seq_phase = PH_CMD_HDR;
        seq_hdr = '0;
        put_byte(r, seq_kind == KIND_PROG ? OP_PROG : OP_ERASE, 1'b1, 1'b0);
      end
      PH_PROG_DATA: begin
        seq_chunk--; seq_left--; seq_addr++;
        if (seq_chunk != 0) seq_phase = PH_WAIT_DATA;
        else begin_poll(r, 1'b1);
      end
      PH_POLL_CMD: begin
        seq_phase = PH_POLL_STAT;
        put_byte(r, DUMMY, 1'b0, 1'b1);
      end
      PH_POLL_STAT: begin
        if (rx[0]) begin
          if (seq_ticks >= tmo_limit) end_cmd(r, ST_TIMEOUT);
          else begin_poll(r, 1'b0);
        end else begin
          if (seq_kind == KIND_ERASE) begin
            seq_addr = seq_addr + 24'd4096;
            seq_left = (seq_left > 24'd4096) ? seq_left - 24'd4096 : '0;
          end
          if (seq_left == 0) end_cmd(r, ST_OK);
          else begin_step(r);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic out_item_t predict_frame(input in_item_t it);
    out_item_t r;
    r = '0;
    if (it.action <= ACT_ERASE) begin
      if (seq_phase != PH_IDLE) r.status = ST_REJECTED;
      else begin
        seq_kind = kind_t'(it.action[1:0]);
        seq_addr = it.address; seq_left = it.length; seq_hdr = '0;
        if (it.action == ACT_READ) begin
          seq_phase = PH_RD_HDR;
          put_byte(r, OP_READ, 1'b1, 1'b0);
        end else if (it.length == 0) end_cmd(r, ST_OK);
        else begin_step(r);
      end
    end else if (it.action == ACT_BYTE) begin
      if (seq_phase != PH_IDLE && seq_phase != PH_WAIT_DATA) begin
        if (it.xfer_error) end_cmd(r, ST_XFER_ERR);
        else spi_byte_done(r, it.rx_byte);
      end
    end else if (it.action == ACT_DATA) begin
      if (seq_phase == PH_WAIT_DATA) begin
        seq_phase = PH_PROG_DATA;
        put_byte(r, it.write_byte, 1'b0, seq_chunk == 1);
      end
    end else if (it.action == ACT_TICK) begin
      if ((seq_phase == PH_POLL_CMD || seq_phase == PH_POLL_STAT) && seq_ticks != 16'hFFFF)
        seq_ticks++;
    end
    r.need_data = (seq_phase == PH_WAIT_DATA);
    r.busy_res = (seq_phase != PH_IDLE);
    return r;
  endfunction

  // Send one item, predicting its result at the transfer; push stays high
  // after the transfer so back-to-back items need no gap
  task automatic send_item(input in_item_t it);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    frame_q.push_back(predict_frame(it));
    sent_items++;
  endtask

  // Check each popped result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (frame_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result);
      end else begin
        out_item_t e;
        e = frame_q.pop_front();
        if (result !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %h act %h", e, result);
        end
      end
    end
    pop <= !(pop_idle > 0 && $urandom_range(99) < pop_idle);
  end

  task automatic drain();
    push <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [15:0] v);
    drain();
    cfg_we <= 1'b1; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tmo_limit = v;
  endtask

  function automatic in_item_t rand_item(input action_t a);
    in_item_t it;
    it.action = a;
    it.address = 24'($urandom);
    it.length = 24'($urandom);
    it.rx_byte = 8'($urandom);
    it.xfer_error = 1'b0;
    it.write_byte = 8'($urandom);
    return it;
  endfunction

  task automatic send_act(input action_t a, input logic [7:0] rx, input logic err);
    in_item_t it;
    it = rand_item(a);
    it.rx_byte = rx; it.xfer_error = err;
    send_item(it);
  endtask

  task automatic send_cmd(input action_t a, input logic [23:0] ad, input logic [23:0] ln);
    in_item_t it;
    it = rand_item(a);
    it.address = ad; it.length = ln;
    send_item(it);
  endtask

  // Answer the engine until it goes idle: random status, ticks, rare errors
  task automatic run_command(input int err_pct, input int busy_pct);
    int guard;
    guard = 0;
    while (seq_phase != PH_IDLE && guard < 400) begin
      guard++;
      if (seq_phase == PH_WAIT_DATA) send_act(ACT_DATA, 8'($urandom), 1'b0);
      else begin
        if (seq_phase inside {PH_POLL_CMD, PH_POLL_STAT} && $urandom_range(3) == 0)
          send_act(ACT_TICK, 8'($urandom), 1'b0);
        if (seq_phase == PH_POLL_STAT)
          send_act(ACT_BYTE, {7'($urandom_range(127)), ($urandom_range(99) < busy_pct)},
                   $urandom_range(99) < err_pct);
        else send_act(ACT_BYTE, 8'($urandom), $urandom_range(99) < err_pct);
      end
    end
    if (seq_phase != PH_IDLE) send_act(ACT_BYTE, 8'h00, 1'b1);
  endtask

  task automatic test_directed();
    send_cmd(ACT_READ, 24'hFFFFFF, 24'd0);
    send_cmd(ACT_PROG, 24'd0, 24'd1);
    run_command(0, 0);
    send_cmd(ACT_READ, 24'hABCDEF, 24'd2);
    send_cmd(ACT_ERASE, 24'd0, 24'd5);
    run_command(0, 0);
    send_cmd(ACT_PROG, 24'd0, 24'd0);
    send_cmd(ACT_ERASE, 24'd0, 24'd0);
    send_act(ACT_BYTE, 8'hFF, 1'b1);
    send_act(ACT_DATA, 8'hFF, 1'b0);
    send_act(ACT_TICK, 8'h00, 1'b0);
    send_act(ACT_RSV6, 8'h00, 1'b0);
    send_act(ACT_RSV7, 8'h00, 1'b1);
    send_cmd(ACT_PROG, 24'hFFFFFE, 24'd3);
    send_act(ACT_BYTE, 8'h00, 1'b1);
  endtask

  task automatic test_timeout();
    set_timeout(16'd0);
    send_cmd(ACT_ERASE, 24'hFFF000, 24'd1);
    run_command(0, 100);
    set_timeout(16'd2);
    send_cmd(ACT_ERASE, 24'h000100, 24'd1);
    run_command(0, 90);
    set_timeout(16'hFFFF);
    send_cmd(ACT_PROG, 24'h0000FF, 24'd2);
    run_command(0, 50);
  endtask

  task automatic test_random(input int items);
    int stop;
    stop = sent_items + items;
    while (sent_items < stop) begin
      int k;
      k = $urandom_range(9);
      if (k < 8) begin
        send_cmd(action_t'($urandom_range(2)), 24'($urandom),
                 $urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(600)));
        if ($urandom_range(3) == 0) send_cmd(ACT_READ, 24'($urandom), 24'd1);
        run_command(3, 40);
      end else begin
        send_act(action_t'($urandom_range(3, 7)), 8'($urandom), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    tmo_limit = TimeoutReset;
    seq_phase = PH_IDLE; seq_kind = KIND_READ;
    seq_addr = '0; seq_left = '0; seq_chunk = '0; seq_hdr = '0; seq_ticks = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_timeout();
    set_timeout(16'd3);
    send_idle = 61; pop_idle = 0;
    test_random(120);
    drain();
    send_idle = 0; pop_idle = 61;
    set_timeout(16'd1);
    test_random(120);
    send_idle = 28; pop_idle = 28;
    set_timeout(16'd5);
    test_random(120);
    send_idle = 0; pop_idle = 0;
    test_random(120);
    drain();
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

// ===== spi_nor_flash_command_sequencer_core.f =====
src/snfcs_pkg.sv
src/snfcs_front.sv
src/snfcs_engine.sv
src/spi_nor_flash_command_sequencer_core.sv
dv/spi_nor_flash_command_sequencer_core_test.sv
